FILE: rtl/pts_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pts_pkg: shared types and constants
// Status codes, request codes and the task table entry of the
// periodic task scheduler.
// ---------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned TICKS_PER_MS = 10;

  typedef enum logic [2:0] {
    REQ_REGISTER = 3'd0,
    REQ_TICK     = 3'd1,
    REQ_INIT     = 3'd2,
    REQ_DONE     = 3'd3,
    REQ_START    = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_PREINIT   = 3'd0,
    ST_SUSPENDED = 3'd1,
    ST_READY     = 3'd2,
    ST_ACTIVE    = 3'd3,
    ST_FINISHED  = 3'd4,
    ST_ERROR     = 3'd5
  } status_t;

  // Task table entry: status and period live together in one word.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] period;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/periodic_task_scheduler.sv
`default_nettype none
// ---------------------------------------------------------------------------
// periodic_task_scheduler: cooperative task table scheduler
// Keeps status and period per task in a memory and switches tasks on ticks.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one request per
//   transaction: register a task, tick, init report, done report or start.
//   Every request yields exactly one result transaction on out_valid/
//   out_stall with the switch flag, old and new task, current status and
//   elapsed milliseconds.
//   Register, init, done, start and unknown requests pass from acceptance
//   to result through a read of the current entry, the write back if any,
//   a read of the new current entry and the result.
//   A tick walks the task table one entry after another, reading each
//   before it checks it; each finished cyclic task other than the current
//   one also passes through the serial remainder unit. A successor is
//   searched for only when the current task is finished or has period
//   zero.
//   The block works on one request at a time. A result waits in the output
//   register while the receiver stalls, and no new request is taken then.
//   Reset marks every table entry preinit with period zero, makes the last
//   slot current and clears the tick counter; no clearing pass is needed.
// ---------------------------------------------------------------------------
module periodic_task_scheduler
  import pts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [2:0]  in_task_index,
  input  wire logic [15:0] in_period_ms,
  input  wire logic        in_init_ok,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_switch_request,
  output logic [2:0]       out_from_task,
  output logic [2:0]       out_to_task,
  output logic [2:0]       out_current_status,
  output logic [28:0]      out_elapsed_ms
);

  localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [AW-1:0] LAST = AW'(MAX_TASKS - 1);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_RDCUR   = 11'b00000000010,
    S_CUR     = 11'b00000000100,
    S_SCAN_RD = 11'b00000001000,
    S_SCAN    = 11'b00000010000,
    S_MOD     = 11'b00000100000,
    S_SEL_RD  = 11'b00001000000,
    S_SEL     = 11'b00010000000,
    S_SW_RD   = 11'b00100000000,
    S_FIN_RD  = 11'b01000000000,
    S_FIN     = 11'b10000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    req_r;
  logic [2:0]    idx_r;
  logic [15:0]   per_r;
  logic          ok_r;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] from_r;
  logic [31:0]   tick_r, tick_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          sw_r, sw_nxt;
  entry_t        cur_ent_r, cur_ent_nxt;
  entry_t        hold_r, hold_nxt;
  logic          ovld_r;
  logic [2:0]    osts_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;
  logic          mod_start, mod_busy, mod_zero;

  // Elapsed time: tick / 10 by reciprocal multiply (exact for 32-bit values)
  logic [63:0]   recip;
  assign recip = {32'd0, tick_r} * 64'hCCCCCCCD;

  pts_table #(.DEPTH(MAX_TASKS), .AW(AW)) u_table (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  pts_modchk u_mod (
    .clk, .rst_n, .start(mod_start), .dividend(tick_r), .period(rd_data.period),
    .busy(mod_busy), .is_zero(mod_zero)
  );

  assign in_stall = (state_r != S_IDLE) || (ovld_r && out_stall);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    tick_nxt    = tick_r;
    ptr_nxt     = ptr_r;
    sw_nxt      = sw_r;
    cur_ent_nxt = cur_ent_r;
    hold_nxt    = hold_r;
    wr_en       = 1'b0;
    wr_addr     = cur_r;
    wr_data     = cur_ent_r;
    rd_addr     = cur_r;
    mod_start   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          state_nxt = S_RDCUR;
          sw_nxt    = 1'b0;
        end
      end
      // Start reads the last slot, every other request the current task's entry
      S_RDCUR: begin
        if (req_r == REQ_START) begin
          rd_addr = LAST;
        end
        state_nxt = S_CUR;
      end
      S_CUR: begin
        cur_ent_nxt = rd_data;
        state_nxt   = S_FIN_RD;
        case (req_r)
          REQ_REGISTER: begin
            if (32'(idx_r) < MAX_TASKS) begin
              wr_en   = 1'b1;
              wr_addr = AW'(idx_r);
              wr_data = '{status: (per_r == 16'd0) ? ST_SUSPENDED : ST_PREINIT,
                          period: per_r};
            end
          end
          REQ_TICK: begin
            tick_nxt  = tick_r + 32'd1;
            ptr_nxt   = '0;
            state_nxt = S_SCAN_RD;
          end
          REQ_INIT: begin
            if (rd_data.status == ST_PREINIT) begin
              wr_en   = 1'b1;
              wr_data = '{status: ok_r ? ST_READY : ST_ERROR, period: rd_data.period};
            end
          end
          REQ_DONE: begin
            if (rd_data.status != ST_PREINIT && rd_data.status != ST_FINISHED) begin
              wr_en   = 1'b1;
              wr_data = '{status: ST_FINISHED, period: rd_data.period};
            end
          end
          REQ_START: begin
            wr_en   = 1'b1;
            wr_addr = LAST;
            wr_data = '{status: ST_ACTIVE, period: rd_data.period};
            cur_nxt = LAST;
          end
          default: ;
        endcase
      end
      // Ready pass: reads and checks one entry after another
      S_SCAN_RD: begin
        rd_addr   = ptr_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        hold_nxt = rd_data;
        if (ptr_r != cur_r && rd_data.period != 16'd0 &&
            rd_data.status == ST_FINISHED) begin
          mod_start = 1'b1;
          state_nxt = S_MOD;
        end else if (32'(ptr_r) == MAX_TASKS - 1) begin
          state_nxt = S_SEL_RD;
          ptr_nxt   = '0;
        end else begin
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_MOD: begin
        if (!mod_busy && !mod_start) begin
          if (mod_zero) begin
            wr_en   = 1'b1;
            wr_addr = ptr_r;
            wr_data = '{status: ST_READY, period: hold_r.period};
          end
          if (32'(ptr_r) == MAX_TASKS - 1) begin
            state_nxt = S_SEL_RD;
            ptr_nxt   = '0;
          end else begin
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = S_SCAN_RD;
          end
        end
      end
      // Selection pass, current entry unchanged by the ready pass
      S_SEL_RD: begin
        if (cur_ent_r.period != 16'd0 && cur_ent_r.status != ST_FINISHED) begin
          state_nxt = S_FIN_RD;
        end else begin
          rd_addr   = ptr_r;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (ptr_r != cur_r && (rd_data.status == ST_PREINIT ||
            rd_data.status == ST_READY || rd_data.status == ST_SUSPENDED)) begin
          wr_en = 1'b1;
          wr_addr = cur_r;
          wr_data = '{status: (cur_ent_r.status == ST_FINISHED) ? ST_FINISHED
                              : ST_SUSPENDED, period: cur_ent_r.period};
          hold_nxt = '{status: (rd_data.status == ST_PREINIT) ? ST_PREINIT
                               : ST_ACTIVE, period: rd_data.period};
          cur_nxt   = ptr_r;
          sw_nxt    = 1'b1;
          state_nxt = S_SW_RD;
        end else if (32'(ptr_r) == MAX_TASKS - 1) begin
          state_nxt = S_FIN_RD;
        end else begin
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = S_SEL_RD;
        end
      end
      // Write the new current entry of a switch
      S_SW_RD: begin
        wr_en     = 1'b1;
        wr_addr   = cur_r;
        wr_data   = hold_r;
        state_nxt = S_FIN_RD;
      end
      S_FIN_RD: begin
        rd_addr   = cur_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= LAST;
      tick_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      tick_r  <= tick_nxt;
      if (state_r == S_FIN) begin
        ovld_r <= 1'b1;
      end else if (!out_stall) begin
        ovld_r <= 1'b0;
      end
    end
    ptr_r     <= ptr_nxt;
    sw_r      <= sw_nxt;
    cur_ent_r <= cur_ent_nxt;
    hold_r    <= hold_nxt;
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      req_r  <= in_req_type;
      idx_r  <= in_task_index;
      per_r  <= in_period_ms;
      ok_r   <= in_init_ok;
      from_r <= cur_r;
    end
    if (state_r == S_FIN) begin
      osts_r <= rd_data.status;
    end
  end

  assign out_valid          = ovld_r;
  assign out_switch_request = sw_r;
  assign out_from_task      = 3'(from_r);
  assign out_to_task        = 3'(cur_r);
  assign out_current_status = osts_r;
  assign out_elapsed_ms     = recip[63:35];

endmodule
`default_nettype wire

FILE: rtl/pts_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pts_table: task table memory
// One write port, one read port, registered read data. Entries that were
// never written since reset read as preinit with period zero.
// ---------------------------------------------------------------------------
module pts_table
  import pts_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t            mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic              rd_vld_r;
  entry_t            rd_raw_r;

  // Write port and valid bits
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_raw_r <= mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  always_comb begin
    rd_data = rd_raw_r;
    if (!rd_vld_r) begin
      rd_data = '{status: ST_PREINIT, period: 16'd0};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pts_modchk.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pts_modchk: multi-cycle divisibility test
// Computes count mod (period*10) by restoring subtraction, one quotient bit
// a cycle over the 32 dividend bits; reports whether the remainder is zero.
// ---------------------------------------------------------------------------
module pts_modchk (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] period,
  output logic             busy,
  output logic             is_zero
);

  logic [5:0]  cnt_r,  cnt_nxt;
  logic [31:0] num_r,  num_nxt;
  logic [32:0] rem_r,  rem_nxt;
  logic [19:0] div_r,  div_nxt;
  logic [32:0] trial;

  assign busy    = (cnt_r != 6'd0);
  assign is_zero = (rem_r == 33'd0);
  assign trial   = {rem_r[31:0], num_r[31]};

  // Shift in one dividend bit and subtract when it fits
  always_comb begin
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    if (start) begin
      cnt_nxt = 6'd32;
      num_nxt = dividend;
      rem_nxt = '0;
      div_nxt = 20'({4'd0, period} * 20'd10);
    end else if (busy) begin
      cnt_nxt = cnt_r - 6'd1;
      num_nxt = {num_r[30:0], 1'b0};
      rem_nxt = (trial >= {13'd0, div_r}) ? trial - {13'd0, div_r} : trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

endmodule
`default_nettype wire
